### rtl/core/grus_pkg.sv
// ----------------------------------------------------------------------------
// grus_pkg
// Shared types and constants for the ring unit search block.
// ----------------------------------------------------------------------------
package grus_pkg;

  localparam int GRID_SIDE_DEF  = 64;
  localparam int MAX_RANGE_DEF  = 3;
  localparam int UNIT_BITS_DEF  = 12;
  localparam int OWNER_BITS_DEF = 4;

  localparam int COORD_W     = 6;
  localparam int OWNER_W     = 4;
  localparam int UNIT_W      = 12;
  localparam int RANGE_W     = 2;
  localparam int DIM_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int WALK_W      = 8;
  localparam int SIDE_STEP   = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = CFG_INDEX_W'(1);

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_occupied;
    logic [OWNER_W-1:0] cell_owner;
    logic [UNIT_W-1:0]  cell_unit;
    logic [RANGE_W-1:0] search_range;
    logic               want_hostile;
    logic               want_all;
    logic [OWNER_W-1:0] player;
  } request_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_id;
    logic              is_match;
    logic              success;
    logic              last;
  } result_t;

  typedef struct packed {
    logic start;
    logic step;
    logic halt;
  } walk_cmd_t;

  typedef struct packed {
    logic active;
    logic on_grid;
  } walk_stat_t;

endpackage

### rtl/core/grus_channels.sv
// ----------------------------------------------------------------------------
// grus_channels
// Valid/ready channels for request and result transfers.
// ----------------------------------------------------------------------------
interface grus_request_if;
  import grus_pkg::*;

  logic     valid;
  logic     ready;
  request_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grus_result_if;
  import grus_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/grus_cell_mem.sv
// ----------------------------------------------------------------------------
// grus_cell_mem
// Cell store: one write port, one registered read port with read enable.
// ----------------------------------------------------------------------------
module grus_cell_mem #(
  parameter int GRID_SIDE  = grus_pkg::GRID_SIDE_DEF,
  parameter int WORD_W     = 1 + grus_pkg::OWNER_BITS_DEF + grus_pkg::UNIT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] waddr,
  input  logic [WORD_W-1:0]                      wdata,
  input  logic                                   re,
  input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] raddr,
  output logic [WORD_W-1:0]                      rdata
);
  localparam int DEPTH = GRID_SIDE * GRID_SIDE;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/grus_ring_walker.sv
// ----------------------------------------------------------------------------
// grus_ring_walker
// Steps through square rings around a centre, clockwise from the top-left
// corner, one cell per step; flags cells on the grid and forms their address.
// ----------------------------------------------------------------------------
module grus_ring_walker #(
  parameter int GRID_SIDE = grus_pkg::GRID_SIDE_DEF,
  parameter int MAX_RANGE = grus_pkg::MAX_RANGE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  grus_pkg::walk_cmd_t                    cmd,
  input  logic [grus_pkg::COORD_W-1:0]           start_x,
  input  logic [grus_pkg::COORD_W-1:0]           start_y,
  input  logic [grus_pkg::RANGE_W-1:0]           start_range,
  input  logic [grus_pkg::WALK_W-1:0]            dim_w,
  input  logic [grus_pkg::WALK_W-1:0]            dim_h,
  output grus_pkg::walk_stat_t                   stat,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] addr
);
  import grus_pkg::*;

  localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int PROD_W = ADDR_W + WALK_W;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  logic signed [WALK_W-1:0] walk_x, walk_x_next;
  logic signed [WALK_W-1:0] walk_y, walk_y_next;
  dir_t                     dir, dir_next;
  logic [2:0]               steps_left, steps_left_next;
  logic [2:0]               side_len, side_len_next;
  logic [RANGE_W-1:0]       rings_left, rings_left_next;
  logic                     active, active_next;
  logic [RANGE_W-1:0]       rings_sat;
  logic [PROD_W-1:0]        addr_full;

  assign rings_sat = (start_range > RANGE_W'(MAX_RANGE)) ? RANGE_W'(MAX_RANGE) : start_range;

  always_comb begin
    walk_x_next     = walk_x;
    walk_y_next     = walk_y;
    dir_next        = dir;
    steps_left_next = steps_left - 3'd1;
    side_len_next   = side_len;
    rings_left_next = rings_left;
    active_next     = active;
    unique case (dir)
      DIR_RIGHT: walk_x_next = walk_x + 8'sd1;
      DIR_DOWN:  walk_y_next = walk_y + 8'sd1;
      DIR_LEFT:  walk_x_next = walk_x - 8'sd1;
      DIR_UP:    walk_y_next = walk_y - 8'sd1;
    endcase
    if (steps_left == 3'd1) begin
      if (dir == DIR_UP) begin
        // ring closed: move out to the next ring's top-left corner
        walk_x_next     = walk_x - 8'sd1;
        walk_y_next     = walk_y - 8'sd2;
        dir_next        = DIR_RIGHT;
        side_len_next   = side_len + 3'(SIDE_STEP);
        steps_left_next = side_len_next;
        rings_left_next = rings_left - RANGE_W'(1);
        active_next     = (rings_left != RANGE_W'(1));
      end else begin
        dir_next        = dir_t'(dir + 2'd1);
        steps_left_next = side_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      walk_x     <= '0;
      walk_y     <= '0;
      dir        <= DIR_RIGHT;
      steps_left <= '0;
      side_len   <= '0;
      rings_left <= '0;
    end else if (cmd.start) begin
      active     <= (rings_sat != '0);
      walk_x     <= $signed({2'b00, start_x}) - 8'sd1;
      walk_y     <= $signed({2'b00, start_y}) - 8'sd1;
      dir        <= DIR_RIGHT;
      steps_left <= 3'(SIDE_STEP);
      side_len   <= 3'(SIDE_STEP);
      rings_left <= rings_sat;
    end else if (cmd.halt) begin
      active <= 1'b0;
    end else if (cmd.step && active) begin
      active     <= active_next;
      walk_x     <= walk_x_next;
      walk_y     <= walk_y_next;
      dir        <= dir_next;
      steps_left <= steps_left_next;
      side_len   <= side_len_next;
      rings_left <= rings_left_next;
    end
  end

  assign stat.active  = active;
  assign stat.on_grid = !walk_x[WALK_W-1] && !walk_y[WALK_W-1] &&
                        (walk_x[WALK_W-1:0] < dim_w) && (walk_y[WALK_W-1:0] < dim_h);

  assign addr_full = PROD_W'(walk_y[WALK_W-1:0]) * PROD_W'(GRID_SIDE) +
                     PROD_W'(walk_x[WALK_W-1:0]);
  assign addr      = stat.on_grid ? addr_full[ADDR_W-1:0] : '0;

endmodule

### rtl/core/grid_ring_unit_search.sv
// ----------------------------------------------------------------------------
// grid_ring_unit_search
// Occupancy grid with a square-ring unit search around a centre cell.
// ----------------------------------------------------------------------------
//  channel   dir  payload                              transfer when
//  request   in   func, cell, owner, unit, search args valid & ready
//  result    out  unit_id, is_match, success, last     valid & ready
//  cfg       in   cfg_index, cfg_data                  cfg_we
//
//  Requests are taken in the idle state; a write goes into the store as it
//  is taken. A search of range r reads up to 4r(r+1) ring cells (8, 24, 48),
//  one per cycle while results are taken, from the single read port of the
//  cell store; it ends with a closing status, or at its first match in
//  single mode. After reset a clearing pass over all GRID_SIDE*GRID_SIDE
//  cells (4096) zeroes the store; no request is taken meanwhile.
//  A result not taken freezes the walk; the next request is taken while the
//  last result of a search still waits.
// ----------------------------------------------------------------------------
module grid_ring_unit_search #(
  parameter int GRID_SIDE  = grus_pkg::GRID_SIDE_DEF,
  parameter int MAX_RANGE  = grus_pkg::MAX_RANGE_DEF,
  parameter int UNIT_BITS  = grus_pkg::UNIT_BITS_DEF,
  parameter int OWNER_BITS = grus_pkg::OWNER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [grus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [grus_pkg::DIM_W-1:0]       cfg_data,
  grus_request_if.sink                     request,
  grus_result_if.source                    result
);
  import grus_pkg::*;

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 1 + OWNER_BITS + UNIT_BITS;
  localparam int PROD_W = ADDR_W + COORD_W;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WALK  = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [DIM_W-1:0]        grid_width, grid_height;
  logic [WALK_W-1:0]       eff_w, eff_h;
  logic [ADDR_W-1:0]       clear_addr;

  logic                    req_take, req_write, req_search, in_store;
  logic [PROD_W-1:0]       waddr_full;
  logic [UNIT_BITS+UNIT_W-1:0]   unit_in_wide;
  logic [OWNER_BITS+OWNER_W-1:0] owner_in_wide, player_wide;
  logic [UNIT_BITS+UNIT_W-1:0]   unit_out_wide;

  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, walk_addr;
  logic [WORD_W-1:0]       mem_wdata, mem_rdata;

  walk_cmd_t               walk_cmd;
  walk_stat_t              walk_stat;

  logic [OWNER_BITS-1:0]   player_q;
  logic                    hostile_q, list_q, found_q;
  logic                    s1_valid, s1_on_grid;

  logic                    adv, same_owner, hit;
  logic                    load_match, load_close, stop_single;
  logic                    rd_occ;
  logic [OWNER_BITS-1:0]   rd_owner;
  logic [UNIT_BITS-1:0]    rd_unit;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_RESET;
      grid_height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  assign eff_w = ({2'b00, grid_width} > 9'(GRID_SIDE)) ? WALK_W'(GRID_SIDE)
                                                       : WALK_W'(grid_width);
  assign eff_h = ({2'b00, grid_height} > 9'(GRID_SIDE)) ? WALK_W'(GRID_SIDE)
                                                        : WALK_W'(grid_height);

  // request side
  assign request.ready = (state == ST_IDLE);
  assign req_take      = request.valid && request.ready;
  assign req_write     = req_take && (request.data.func == FUNC_WRITE);
  assign req_search    = req_take && (request.data.func == FUNC_SEARCH);
  assign in_store      = ({3'b000, request.data.cell_x} < 9'(GRID_SIDE)) &&
                         ({3'b000, request.data.cell_y} < 9'(GRID_SIDE));
  assign waddr_full    = PROD_W'(request.data.cell_y) * PROD_W'(GRID_SIDE) +
                         PROD_W'(request.data.cell_x);

  assign unit_in_wide  = (UNIT_BITS+UNIT_W)'(request.data.cell_unit);
  assign owner_in_wide = (OWNER_BITS+OWNER_W)'(request.data.cell_owner);
  assign player_wide   = (OWNER_BITS+OWNER_W)'(request.data.player);

  assign mem_we    = (state == ST_CLEAR) || (req_write && in_store);
  assign mem_waddr = (state == ST_CLEAR) ? clear_addr : waddr_full[ADDR_W-1:0];
  assign mem_wdata = (state == ST_CLEAR) ? '0 :
                     {request.data.cell_occupied, owner_in_wide[OWNER_BITS-1:0],
                      unit_in_wide[UNIT_BITS-1:0]};

  grus_cell_mem #(
    .GRID_SIDE (GRID_SIDE),
    .WORD_W    (WORD_W)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (walk_addr),
    .rdata (mem_rdata)
  );

  grus_ring_walker #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_RANGE (MAX_RANGE)
  ) u_ring_walker (
    .clk         (clk),
    .rst         (rst),
    .cmd         (walk_cmd),
    .start_x     (request.data.cell_x),
    .start_y     (request.data.cell_y),
    .start_range (request.data.search_range),
    .dim_w       (eff_w),
    .dim_h       (eff_h),
    .stat        (walk_stat),
    .addr        (walk_addr)
  );

  // match evaluation on the read data
  assign adv        = !result.valid || result.ready;
  assign rd_occ     = mem_rdata[WORD_W-1];
  assign rd_owner   = mem_rdata[UNIT_BITS +: OWNER_BITS];
  assign rd_unit    = mem_rdata[UNIT_BITS-1:0];
  assign same_owner = (rd_owner == player_q);
  assign hit        = s1_valid && s1_on_grid && rd_occ && (hostile_q ? !same_owner : same_owner);

  assign load_match  = (state == ST_WALK) && adv && hit;
  assign load_close  = (state == ST_WALK) && adv && !s1_valid && !walk_stat.active;
  assign stop_single = load_match && !list_q;

  assign walk_cmd.start = req_search;
  assign walk_cmd.step  = (state == ST_WALK) && adv;
  assign walk_cmd.halt  = stop_single;
  assign mem_re         = (state == ST_WALK) && adv && walk_stat.active;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clear_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (req_search) state_next = ST_WALK;
      ST_WALK:  if (stop_single || load_close) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      s1_valid   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
      if (req_search) begin
        s1_valid <= 1'b0;
        found_q  <= 1'b0;
      end else if ((state == ST_WALK) && adv) begin
        s1_valid <= walk_stat.active && !stop_single;
        if (load_match) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_search) begin
      player_q  <= player_wide[OWNER_BITS-1:0];
      hostile_q <= request.data.want_hostile;
      list_q    <= request.data.want_all;
    end
    if (mem_re) begin
      s1_on_grid <= walk_stat.on_grid;
    end
  end

  // result register
  assign unit_out_wide = (UNIT_BITS+UNIT_W)'(rd_unit);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_match || load_close) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_match) begin
      result.data.unit_id  <= unit_out_wide[UNIT_W-1:0];
      result.data.is_match <= 1'b1;
      result.data.success  <= 1'b1;
      result.data.last     <= !list_q;
    end else if (load_close) begin
      result.data.unit_id  <= '0;
      result.data.is_match <= 1'b0;
      result.data.success  <= list_q && found_q;
      result.data.last     <= 1'b1;
    end
  end

  a_match_success : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.is_match |-> result.data.success)
    else $error("match record without success");

  a_close_form : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.is_match |-> result.data.last && (result.data.unit_id == '0))
    else $error("closing status malformed");

  a_walker_idle : assert property (@(posedge clk) disable iff (rst)
    (state != ST_WALK) |-> !walk_stat.active)
    else $error("walker active outside a search");

  a_no_write_in_walk : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !mem_we)
    else $error("cell store written during a search");

endmodule

### tb/grus_search_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grus_search_check
// Watches the request, result and register ports of the ring unit search
// block. Keeps its own copy of the grid and the grid size, works out the
// results of every search as it is accepted, and compares each result
// transfer field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module grus_search_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [grus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [grus_pkg::DIM_W-1:0]       cfg_data,
  grus_request_if                          request,
  grus_result_if                           result,
  output int                               fail_count,
  output int                               pending_results
);
  import grus_pkg::*;

  localparam int SIDE = GRID_SIDE_DEF;

  typedef enum logic [1:0] {GO_RIGHT, GO_DOWN, GO_LEFT, GO_UP} heading_t;

  typedef struct packed {
    logic               occupied;
    logic [OWNER_W-1:0] owner;
    logic [UNIT_W-1:0]  unit;
  } grid_cell_t;

  grid_cell_t       grid [SIDE*SIDE];
  logic [DIM_W-1:0] grid_w;
  logic [DIM_W-1:0] grid_h;
  result_t          ring_results [$];
  result_t          want;
  result_t          got;

  task automatic walk_rings(input request_t r);
    int         w;
    int         h;
    int         x;
    int         y;
    int         side;
    int         rings;
    int         hits;
    grid_cell_t c;
    result_t    e;
    heading_t   hd;
    w     = (grid_w > SIDE) ? SIDE : int'(grid_w);
    h     = (grid_h > SIDE) ? SIDE : int'(grid_h);
    rings = (r.search_range > MAX_RANGE_DEF) ? MAX_RANGE_DEF : int'(r.search_range);
    x     = int'(r.cell_x) - 1;
    y     = int'(r.cell_y) - 1;
    side  = SIDE_STEP;
    hits  = 0;
    for (int ring = 0; ring < rings; ring++) begin
      for (int d = 0; d < 4; d++) begin
        hd = heading_t'(d);
        for (int s = 0; s < side; s++) begin
          if (x >= 0 && y >= 0 && x < w && y < h) begin
            c = grid[y * SIDE + x];
            if (c.occupied && ((c.owner != r.player) == r.want_hostile)) begin
              hits++;
              e.unit_id  = c.unit;
              e.is_match = 1'b1;
              e.success  = 1'b1;
              e.last     = !r.want_all;
              ring_results.push_back(e);
              if (!r.want_all) return;
            end
          end
          case (hd)
            GO_RIGHT: x++;
            GO_DOWN:  y++;
            GO_LEFT:  x--;
            default:  y--;
          endcase
        end
      end
      // next ring starts one cell up and left of this one
      x--;
      y--;
      side += SIDE_STEP;
    end
    e.unit_id  = '0;
    e.is_match = 1'b0;
    e.success  = r.want_all && hits > 0;
    e.last     = 1'b1;
    ring_results.push_back(e);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (grid[i]) grid[i] = '0;
      grid_w = DIM_RESET;
      grid_h = DIM_RESET;
      ring_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_WIDTH) grid_w = cfg_data;
        else grid_h = cfg_data;
      end
      if (result.valid && result.ready) begin
        got = result.data;
        if (ring_results.size() == 0) begin
          $error("result transfer with nothing outstanding: unit_id %0h", got.unit_id);
          fail_count++;
        end else begin
          want = ring_results.pop_front();
          if (got.unit_id !== want.unit_id) begin
            $error("unit_id: expected %0h, got %0h", want.unit_id, got.unit_id);
            fail_count++;
          end
          if (got.is_match !== want.is_match) begin
            $error("is_match: expected %0b, got %0b", want.is_match, got.is_match);
            fail_count++;
          end
          if (got.success !== want.success) begin
            $error("success: expected %0b, got %0b", want.success, got.success);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fail_count++;
          end
        end
      end
      if (request.valid && request.ready) begin
        if (request.data.func == FUNC_WRITE) begin
          grid[request.data.cell_y * SIDE + request.data.cell_x] =
            {request.data.cell_occupied, request.data.cell_owner, request.data.cell_unit};
        end else begin
          walk_rings(request.data);
        end
      end
    end
    pending_results = ring_results.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ring unit search block. A directed part covers the grid
// corners, rings cut by the grid edge, the centre cell, range zero, friendly
// and hostile, single and list searches, and the grid size registers at zero,
// one and above the store size. Random phases follow, each with its own grid
// size: writes cluster around a hot cell that searches then walk, with some
// fully random requests mixed in. Both handshakes are throttled at random,
// but for one calm phase.
module tb;
  import grus_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DIM_W-1:0]       cfg_data;
  int                     fail_count;
  int                     pending_results;
  bit                     calm = 1'b0;
  int                     hot_x;
  int                     hot_y;
  logic [OWNER_W-1:0]     pa;
  logic [OWNER_W-1:0]     pb;

  grus_request_if req_ch ();
  grus_result_if  res_ch ();

  grid_ring_unit_search i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .result    (res_ch)
  );

  grus_search_check i_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .request         (req_ch),
    .result          (res_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t random_request();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(request_t)-1:0];
  endfunction

  function automatic request_t mk_write(input int x, input int y, input logic occ,
                                        input logic [OWNER_W-1:0] owner,
                                        input logic [UNIT_W-1:0] unit);
    request_t r;
    r               = random_request();
    r.func          = FUNC_WRITE;
    r.cell_x        = COORD_W'(x);
    r.cell_y        = COORD_W'(y);
    r.cell_occupied = occ;
    r.cell_owner    = owner;
    r.cell_unit     = unit;
    return r;
  endfunction

  function automatic request_t mk_search(input int x, input int y, input int rings,
                                         input logic hostile, input logic all,
                                         input logic [OWNER_W-1:0] player);
    request_t r;
    r              = random_request();
    r.func         = FUNC_SEARCH;
    r.cell_x       = COORD_W'(x);
    r.cell_y       = COORD_W'(y);
    r.search_range = RANGE_W'(rings);
    r.want_hostile = hostile;
    r.want_all     = all;
    r.player       = player;
    return r;
  endfunction

  function automatic int near(input int c);
    int v;
    v = c + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // centre range for a grid dimension: inside, or just past the edge
  function automatic int span(input int d);
    if (d == 0) return 3;
    if (d > 63) return 63;
    return d;
  endfunction

  function automatic int rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return $urandom_range(65, 127);
    if (r < 35) return 64;
    return $urandom_range(1, 20);
  endfunction

  function automatic request_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return random_request();
    if (pick < 65) begin
      return mk_write(near(hot_x), near(hot_y), $urandom_range(0, 4) != 0,
                      $urandom_range(0, 2) == 0 ? OWNER_W'($urandom) :
                      ($urandom_range(0, 1) ? pa : pb), UNIT_W'($urandom));
    end
    return mk_search($urandom_range(0, 3) == 0 ? near(hot_x) : hot_x,
                     $urandom_range(0, 3) == 0 ? near(hot_y) : hot_y,
                     $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? pa : pb);
  endfunction

  // called at a falling edge; leaves valid high when the next transfer follows
  task automatic send(input request_t r);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    gap = 0;
    if (!calm && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic set_dims(input int w, input int h);
    req_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(negedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : sink_pacing
    int stall;
    stall        = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL grid_ring_unit_search");
    $finish;
  end

  initial begin
    int w;
    int h;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_GRID_WIDTH;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // empty grid
    send(mk_search(0, 0, 3, 1'b0, 1'b0, 4'd0));
    send(mk_search(63, 63, 3, 1'b1, 1'b1, 4'd15));
    // cells around (10,10): ring one, ring three, centre, unoccupied
    send(mk_write(9, 9, 1'b1, 4'd5, 12'hFFF));
    send(mk_write(11, 11, 1'b1, 4'd3, 12'h001));
    send(mk_write(13, 7, 1'b1, 4'd5, 12'hABC));
    send(mk_write(10, 10, 1'b1, 4'd5, 12'h123));
    send(mk_write(10, 9, 1'b0, 4'd5, 12'h555));
    send(mk_search(10, 10, 3, 1'b0, 1'b1, 4'd5));
    send(mk_search(10, 10, 3, 1'b0, 1'b0, 4'd5));
    send(mk_search(10, 10, 3, 1'b1, 1'b1, 4'd5));
    send(mk_search(10, 10, 0, 1'b0, 1'b1, 4'd5));
    // grid corners, rings cut by the edge
    send(mk_write(0, 0, 1'b1, 4'd15, 12'h000));
    send(mk_write(63, 63, 1'b1, 4'd15, 12'hFFF));
    send(mk_search(1, 1, 2, 1'b1, 1'b1, 4'd0));
    send(mk_search(62, 62, 3, 1'b0, 1'b0, 4'd15));
    send(mk_write(9, 9, 1'b0, 4'd5, 12'hFFF));
    send(mk_search(10, 10, 1, 1'b0, 1'b0, 4'd5));
    // size registers above the store, at zero, cutting the grid, at one
    set_dims(127, 100);
    send(mk_search(62, 62, 1, 1'b0, 1'b1, 4'd15));
    set_dims(0, 64);
    send(mk_search(10, 10, 3, 1'b1, 1'b1, 4'd5));
    set_dims(12, 9);
    send(mk_write(20, 20, 1'b1, 4'd7, 12'h777));
    send(mk_search(10, 10, 3, 1'b0, 1'b1, 4'd5));
    send(mk_search(19, 19, 1, 1'b1, 1'b0, 4'd0));
    set_dims(64, 64);
    send(mk_search(19, 19, 1, 1'b1, 1'b0, 4'd0));
    set_dims(1, 1);
    send(mk_search(1, 1, 1, 1'b1, 1'b1, 4'd0));

    for (int ph = 0; ph < 5; ph++) begin
      w = rand_dim();
      h = rand_dim();
      set_dims(w, h);
      calm  = (ph == 2);
      hot_x = $urandom_range(0, span(w));
      hot_y = $urandom_range(0, span(h));
      pa    = OWNER_W'($urandom);
      pb    = OWNER_W'($urandom);
      repeat (17) send(random_item());
    end
    req_ch.valid <= 1'b0;
    calm = 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("PASS grid_ring_unit_search");
    else $display("FAIL grid_ring_unit_search");
    $finish;
  end

endmodule
